// ===== hw/rtl/bcc_pkg.sv =====
// Shared types and constants for the button click classifier.
// Holds the event codes, mode codes, register indexes and the config bundle.
// No dependencies.
package bcc_pkg;

	// Result event codes.
	typedef enum logic [1:0] {
		EV_NONE   = 2'd0,
		EV_SINGLE = 2'd1,
		EV_DOUBLE = 2'd2,
		EV_LONG   = 2'd3
	} ev_t;

	// Classifier mode codes.
	localparam int MODE_W = 3;
	localparam logic [MODE_W-1:0] MODE_CLICK       = 3'd0;
	localparam logic [MODE_W-1:0] MODE_CLICK_DBL   = 3'd1;
	localparam logic [MODE_W-1:0] MODE_CLICK_LONG  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_DBL_LONG    = 3'd3;
	localparam logic [MODE_W-1:0] MODE_ALL         = 3'd4;

	// Configuration register indexes.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_MODE         = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_CLICK = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS   = 2'd3;

	// Reset values of the registers.
	localparam logic [MODE_W-1:0]     MODE_RST         = MODE_ALL;
	localparam logic [CFG_DATA_W-1:0] DEBOUNCE_RST     = 16'd20;
	localparam logic [CFG_DATA_W-1:0] DOUBLE_CLICK_RST = 16'd60;
	localparam logic [CFG_DATA_W-1:0] LONG_PRESS_RST   = 16'd300;

	// Number of releases that make a double click.
	localparam logic [1:0] DOUBLE_CLICKS = 2'd2;
	localparam logic [1:0] CLICKS_MAX    = 2'd3;

	typedef struct packed {
		logic [MODE_W-1:0]     mode;
		logic [CFG_DATA_W-1:0] debounce_ticks;
		logic [CFG_DATA_W-1:0] double_click_ticks;
		logic [CFG_DATA_W-1:0] long_press_ticks;
	} cfg_t;

endpackage

// ===== hw/rtl/bcc_cfg_regs.sv =====
// Configuration register file of the button click classifier.
// Depends on bcc_pkg for register indexes, reset values and cfg_t.
module bcc_cfg_regs import bcc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode               <= MODE_RST;
			cfg_q.debounce_ticks     <= DEBOUNCE_RST;
			cfg_q.double_click_ticks <= DOUBLE_CLICK_RST;
			cfg_q.long_press_ticks   <= LONG_PRESS_RST;
		end else if (wr_en) begin
			case (wr_index)
				CFG_MODE:         cfg_q.mode               <= wr_data[MODE_W-1:0];
				CFG_DEBOUNCE:     cfg_q.debounce_ticks     <= wr_data;
				CFG_DOUBLE_CLICK: cfg_q.double_click_ticks <= wr_data;
				CFG_LONG_PRESS:   cfg_q.long_press_ticks   <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== hw/rtl/bcc_core.sv =====
// Debounce and click classification state with its per-step update logic.
// Depends on bcc_pkg for event and mode codes and cfg_t.
module bcc_core import bcc_pkg::*; #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic       pin_level,
	input  cfg_t       cfg,
	output logic [1:0] key_event,
	output logic       pressed_now
);

	localparam int CW    = COUNT_WIDTH;
	localparam int CMP_W = (CW > CFG_DATA_W) ? CW : CFG_DATA_W;

	logic          stable_pressed_q;
	logic          press_pending_q;
	logic [CW-1:0] debounce_count_q;
	logic [CW-1:0] gap_count_q;
	logic [CW-1:0] hold_count_q;
	logic [1:0]    clicks_seen_q;

	logic          sp_d;
	logic          pp_d;
	logic [CW-1:0] dc_d;
	logic [CW-1:0] gc_d;
	logic [CW-1:0] hc_d;
	logic [1:0]    cs_d;
	ev_t           ev_d;

	function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
		return (v == {CW{1'b1}}) ? v : v + 1'b1;
	endfunction

	function automatic logic cnt_ge(input logic [CW-1:0] c, input logic [CFG_DATA_W-1:0] lim);
		return CMP_W'(c) >= CMP_W'(lim);
	endfunction

	always_comb begin
		logic             disagree;
		logic             press_edge;
		logic [MODE_W-1:0] m;

		sp_d       = stable_pressed_q;
		pp_d       = press_pending_q;
		dc_d       = debounce_count_q;
		gc_d       = gap_count_q;
		hc_d       = hold_count_q;
		cs_d       = clicks_seen_q;
		ev_d       = EV_NONE;
		press_edge = 1'b0;
		m          = (cfg.mode > MODE_ALL) ? MODE_ALL : cfg.mode;
		disagree   = stable_pressed_q ? pin_level : !pin_level;

		// Debounce: count disagreeing samples, toggle at the limit.
		if (disagree) begin
			dc_d = sat_inc(dc_d);
			if (cnt_ge(dc_d, cfg.debounce_ticks)) begin
				dc_d       = '0;
				sp_d       = !sp_d;
				press_edge = sp_d;
			end
		end else begin
			dc_d = '0;
		end

		if (m == MODE_CLICK) begin
			if (press_edge) ev_d = EV_SINGLE;
		end else begin
			if (press_edge) pp_d = 1'b1;

			if (m == MODE_CLICK_DBL) begin
				if (sp_d) begin
					if (pp_d && gc_d != '0) begin
						pp_d = 1'b0;
						ev_d = EV_DOUBLE;
					end
					gc_d = '0;
				end else if (pp_d) begin
					gc_d = sat_inc(gc_d);
					if (cnt_ge(gc_d, cfg.double_click_ticks)) begin
						pp_d = 1'b0;
						gc_d = '0;
						ev_d = EV_SINGLE;
					end
				end
			end else if (m == MODE_CLICK_LONG) begin
				if (sp_d) begin
					if (pp_d) begin
						hc_d = sat_inc(hc_d);
						if (cnt_ge(hc_d, cfg.long_press_ticks)) begin
							pp_d = 1'b0;
							hc_d = '0;
							ev_d = EV_LONG;
						end
					end
				end else begin
					if (pp_d) ev_d = EV_SINGLE;
					hc_d = '0;
					pp_d = 1'b0;
				end
			end else begin
				// Double plus long, with or without the single click.
				if (sp_d) begin
					gc_d = '0;
					if (pp_d) begin
						hc_d = sat_inc(hc_d);
						if (cnt_ge(hc_d, cfg.long_press_ticks)) begin
							pp_d = 1'b0;
							hc_d = '0;
							cs_d = '0;
							ev_d = EV_LONG;
						end
					end
				end else begin
					hc_d = '0;
					if (pp_d && cs_d < CLICKS_MAX) cs_d = cs_d + 2'd1;
					pp_d = 1'b0;
					if (cs_d >= DOUBLE_CLICKS) begin
						gc_d = '0;
						cs_d = '0;
						ev_d = EV_DOUBLE;
					end
					if (cs_d != '0) begin
						gc_d = sat_inc(gc_d);
						if (cnt_ge(gc_d, cfg.double_click_ticks)) begin
							gc_d = '0;
							cs_d = '0;
							if (m == MODE_ALL) ev_d = EV_SINGLE;
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_pressed_q <= 1'b0;
			press_pending_q  <= 1'b0;
			debounce_count_q <= '0;
			gap_count_q      <= '0;
			hold_count_q     <= '0;
			clicks_seen_q    <= '0;
		end else if (step) begin
			stable_pressed_q <= sp_d;
			press_pending_q  <= pp_d;
			debounce_count_q <= dc_d;
			gap_count_q      <= gc_d;
			hold_count_q     <= hc_d;
			clicks_seen_q    <= cs_d;
		end
	end

	assign key_event   = ev_d;
	assign pressed_now = sp_d;

endmodule

// ===== hw/rtl/button_click_classifier_unit.sv =====
// Button click classifier: debounces an active-low pin sample per request and
// classifies single click, double click and long press by the mode register.
// A request passes the input register, then the state update and the result
// register. Throughput is one request per cycle as long as out_stall does not
// hold a full result register.
// Reset clears valids and core state, loads defaults (mode 4, 20, 60, 300).
module button_click_classifier_unit import bcc_pkg::*; #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// Input request channel.
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  pin_level,
	// Result channel.
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [1:0]            key_event,
	output logic                  pressed_now,
	// Configuration write channel.
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t       cfg;
	logic       valid_s1;
	logic       pin_s1;
	logic       valid_s2;
	logic [1:0] event_s2;
	logic       pressed_s2;
	logic [1:0] event_nxt;
	logic       pressed_nxt;
	logic       s2_load;
	logic       s1_load;
	logic       step;

	// Configuration writes are always taken; the user writes only while idle.
	assign cfg_ready = 1'b1;

	bcc_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// The result register can take a new result when it is empty or being
	// drained this cycle. The input register moves forward whenever the
	// result register can load, so a request enters every cycle as long as
	// results keep draining.
	assign s2_load  = !valid_s2 || !out_stall;
	assign step     = valid_s1 && s2_load;
	assign s1_load  = !valid_s1 || s2_load;
	assign in_stall = !s1_load;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_load) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_load && in_valid) begin
			pin_s1 <= pin_level;
		end
	end

	// The classifier state advances exactly once per request, at the edge
	// where the request moves into the result register.
	bcc_core #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.pin_level   (pin_s1),
		.cfg         (cfg),
		.key_event   (event_nxt),
		.pressed_now (pressed_nxt)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_load) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			event_s2   <= event_nxt;
			pressed_s2 <= pressed_nxt;
		end
	end

	assign out_valid   = valid_s2;
	assign key_event   = event_s2;
	assign pressed_now = pressed_s2;

endmodule
